// ===== src/rpfa_pkg.sv =====
package rpfa_pkg;

  localparam int PageCount = 65536;
  localparam int PageBits = $clog2(PageCount);
  localparam int CountBits = 8;
  localparam int TotalBits = PageBits + 1;
  localparam int CfgBits = 17;
  localparam int PnBits = 16;
  localparam int CoutBits = 17;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_ALLOC = 3'd1,
    MODE_FREE  = 3'd2,
    MODE_INC   = 3'd3,
    MODE_DEC   = 3'd4,
    MODE_READ  = 3'd5,
    MODE_TOTAL = 3'd6,
    MODE_NONE  = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_RANGE = 3'd2,
    ST_FULL  = 3'd3,
    ST_SAT   = 3'd4
  } status_t;

  localparam logic CFG_LOWEST = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  // A classified request as handed from the front part to the back part.
  typedef struct packed {
    mode_t             mode;
    logic [PnBits-1:0] page;
    logic              in_range;
  } req_t;

  // Result item.
  typedef struct packed {
    logic [PnBits-1:0]   page_out;
    logic [CoutBits-1:0] count_out;
    logic                page_released;
    status_t             status;
  } res_t;

endpackage

// ===== src/rpfa_ram.sv =====
module rpfa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rpfa_front.sv =====
module rpfa_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [rpfa_pkg::CfgBits-1:0]     cfg_data,
  input  logic                             s_valid,
  output logic                             s_ready,
  input  logic [2:0]                       s_mode,
  input  logic [rpfa_pkg::PnBits-1:0]      s_page,
  output logic                             q_valid,
  input  logic                             q_ready,
  output rpfa_pkg::req_t                   q_req
);
  import rpfa_pkg::*;

  logic [CfgBits-1:0] lowest_page;
  logic [CfgBits-1:0] page_limit;
  req_t               slot [2];
  logic [1:0]         fill;
  logic               wr_ptr;
  logic               rd_ptr;
  logic               push;
  logic               pop;
  req_t               incoming;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_page <= '0;
      page_limit <= CfgBits'(PageCount);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOWEST: lowest_page <= cfg_data;
        CFG_LIMIT:  page_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the request: the range check is done here.
  always_comb begin
    incoming.mode = mode_t'(s_mode);
    incoming.page = s_page;
    incoming.in_range = ({1'b0, s_page} >= lowest_page) &&
                        ({1'b0, s_page} < page_limit);
  end

  assign s_ready = (fill != 2'd2);
  assign push = s_valid && s_ready;
  assign pop = q_valid && q_ready;
  assign q_valid = (fill != 2'd0);
  assign q_req = slot[rd_ptr];

  // Two-entry queue toward the back part.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill overflow");
  assert property (@(posedge clk) disable iff (rst) (fill == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 2'd1))
    else $error("queue fill did not track a push");

endmodule

// ===== src/rpfa_back.sv =====
module rpfa_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  rpfa_pkg::req_t                q_req,
  output logic                          m_valid,
  input  logic                          m_ready,
  output rpfa_pkg::res_t                m_res
);
  import rpfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t               state;
  req_t                 req;
  logic [TotalBits-1:0] free_total;
  logic [PageBits-1:0]  clr_addr;

  logic                 cnt_we;
  logic [PageBits-1:0]  cnt_waddr;
  logic [CountBits-1:0] cnt_wdata;
  logic [PageBits-1:0]  cnt_raddr;
  logic [CountBits-1:0] cnt_rdata;

  logic                 stk_we;
  logic [PageBits-1:0]  stk_waddr;
  logic [PnBits-1:0]    stk_wdata;
  logic [PageBits-1:0]  stk_raddr;
  logic [PnBits-1:0]    stk_rdata;

  logic                 take;
  logic                 exec_ok;
  logic                 full;
  logic [CountBits-1:0] c_new;
  res_t                 res_next;
  logic [TotalBits-1:0] total_next;
  logic                 do_push;

  localparam logic [CountBits-1:0] CountMax = '1;

  rpfa_ram #(.Width(CountBits), .Depth(PageCount)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  rpfa_ram #(.Width(PnBits), .Depth(PageCount)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Take a request when idle and the output register is free.
  assign take = (state == S_IDLE) && q_valid && (!m_valid || m_ready);
  assign q_ready = take;
  assign full = (free_total == TotalBits'(PageCount));
  assign cnt_raddr = q_req.page[PageBits-1:0];
  assign stk_raddr = PageBits'(free_total - TotalBits'(1));
  assign exec_ok = (state == S_EXEC);

  // Execute state: both memory words are read; compute the outcome.
  always_comb begin
    res_next = '0;
    c_new = cnt_rdata;
    do_push = 1'b0;
    total_next = free_total;
    cnt_we = 1'b0;
    cnt_waddr = req.page[PageBits-1:0];
    cnt_wdata = '0;
    case (req.mode)
      MODE_ALLOC: begin
        if (free_total == '0) begin
          res_next.status = ST_EMPTY;
        end else begin
          total_next = free_total - TotalBits'(1);
          res_next.page_out = stk_rdata;
          res_next.count_out = CoutBits'(1);
          cnt_we = 1'b1;
          cnt_waddr = stk_rdata[PageBits-1:0];
          cnt_wdata = CountBits'(1);
        end
      end
      MODE_TOTAL: res_next.count_out = CoutBits'(free_total);
      MODE_NONE: ;
      default: begin
        res_next.page_out = req.page;
        if (!req.in_range) begin
          res_next.status = ST_RANGE;
        end else begin
          case (req.mode)
            MODE_ADD: begin
              c_new = '0;
              cnt_we = 1'b1;
              do_push = 1'b1;
            end
            MODE_FREE: begin
              if (cnt_rdata != '0) c_new = cnt_rdata - CountBits'(1);
              cnt_we = 1'b1;
              do_push = (c_new == '0);
            end
            MODE_INC: begin
              if (cnt_rdata == CountMax) res_next.status = ST_SAT;
              else c_new = cnt_rdata + CountBits'(1);
              cnt_we = 1'b1;
            end
            MODE_DEC: begin
              if (cnt_rdata == '0) res_next.status = ST_SAT;
              else c_new = cnt_rdata - CountBits'(1);
              cnt_we = 1'b1;
            end
            default: ;
          endcase
          cnt_wdata = c_new;
          res_next.count_out = CoutBits'(c_new);
          if (do_push) begin
            if (full) begin
              res_next.status = ST_FULL;
            end else begin
              res_next.page_released = 1'b1;
              total_next = free_total + TotalBits'(1);
            end
          end
        end
      end
    endcase
    cnt_we = cnt_we && exec_ok;
    if (state == S_CLEAR) begin
      cnt_we = 1'b1;
      cnt_waddr = clr_addr;
      cnt_wdata = '0;
    end
  end

  assign stk_we = exec_ok && res_next.page_released;
  assign stk_waddr = free_total[PageBits-1:0];
  assign stk_wdata = req.page;

  always_ff @(posedge clk) begin
    if (take) req <= q_req;
    if (exec_ok) m_res <= res_next;
  end

  // Sequencer: clearing pass after reset, then idle and execute per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      free_total <= '0;
      m_valid <= 1'b0;
    end else begin
      if (m_valid && m_ready) m_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + PageBits'(1);
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: if (take) state <= S_EXEC;
        S_EXEC: begin
          free_total <= total_next;
          m_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    free_total <= TotalBits'(PageCount))
    else $error("free total beyond page count");
  assert property (@(posedge clk) disable iff (rst) exec_ok |=> m_valid)
    else $error("result lost after execution");
  assert property (@(posedge clk) disable iff (rst)
    stk_we |-> (res_next.status == ST_OK))
    else $error("push with error status");
  assert property (@(posedge clk) disable iff (rst) (state == S_CLEAR) |-> !q_ready)
    else $error("request taken during clearing pass");

endmodule

// ===== src/refcounted_page_frame_allocator_top.sv =====
// Path from input transaction to result valid: queue write, then memory read
// and execute into the output register.
// A new request is taken only after the previous one has finished the
// read-modify-write of the count and stack memories.
// Reset (rst, synchronous): clears control state, then a clearing pass over all
// 65536 count words zeroes the count memory; no request is taken during it.
module refcounted_page_frame_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // mode[2:0], page_number[18:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // page_out, count_out, page_released, status
);
  import rpfa_pkg::*;

  logic q_valid;
  logic q_ready;
  req_t q_req;
  res_t res;

  rpfa_front u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
    .s_mode(s_axis_tdata[2:0]), .s_page(s_axis_tdata[18:3]),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  rpfa_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_res(res)
  );

  assign m_axis_tdata = {3'b000, res.status, res.page_released,
                         res.count_out, res.page_out};

endmodule

// ===== verif/refcounted_page_frame_allocator_checker.sv =====
`timescale 1ns / 100ps

module refcounted_page_frame_allocator_checker
  import rpfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          outstanding,
  output int          errors
);

  typedef struct {
    logic [PnBits-1:0]   page_out;
    logic [CoutBits-1:0] count_out;
    logic                page_released;
    status_t             status;
  } grant_t;

  // Shadow copy of the allocator state.
  logic [CountBits-1:0] refcnt [PageCount];
  logic [PnBits-1:0]    stack_mem [PageCount];
  logic [TotalBits-1:0] free_pages;
  logic [CfgBits-1:0]   lowest;
  logic [CfgBits-1:0]   limit;
  grant_t               pending_grants [$];

  function automatic logic push_frame(input logic [PnBits-1:0] pg);
    if (free_pages >= PageCount) return 1'b0;
    stack_mem[free_pages[PageBits-1:0]] = pg;
    free_pages++;
    return 1'b1;
  endfunction

  // Computes the response to one request and updates the shadow state.
  function automatic grant_t serve_request(input mode_t md, input logic [PnBits-1:0] pg);
    grant_t g;
    logic [CountBits-1:0] c;
    g = '{page_out: '0, count_out: '0, page_released: 1'b0, status: ST_OK};
    if (md == MODE_ALLOC) begin
      if (free_pages == 0) begin
        g.status = ST_EMPTY;
      end else begin
        free_pages--;
        g.page_out = stack_mem[free_pages[PageBits-1:0]];
        refcnt[g.page_out] = 1;
        g.count_out = 1;
      end
    end else if (md == MODE_TOTAL) begin
      g.count_out = free_pages;
    end else if (md != MODE_NONE) begin
      g.page_out = pg;
      if ({1'b0, pg} < lowest || {1'b0, pg} >= limit) begin
        g.status = ST_RANGE;
      end else begin
        c = refcnt[pg];
        case (md)
          MODE_ADD: begin
            c = 0;
            if (push_frame(pg)) g.page_released = 1'b1;
            else g.status = ST_FULL;
          end
          MODE_FREE: begin
            if (c > 0) c--;
            if (c == 0) begin
              if (push_frame(pg)) g.page_released = 1'b1;
              else g.status = ST_FULL;
            end
          end
          MODE_INC: begin
            if (c == {CountBits{1'b1}}) g.status = ST_SAT;
            else c++;
          end
          MODE_DEC: begin
            if (c == 0) g.status = ST_SAT;
            else c--;
          end
          default: ;
        endcase
        refcnt[pg] = c;
        g.count_out = c;
      end
    end
    return g;
  endfunction

  assign outstanding = pending_grants.size();

  always @(posedge clk) begin
    grant_t exp_g;
    logic [15:0] a_page;
    logic [16:0] a_count;
    logic        a_rel;
    logic [2:0]  a_st;
    if (rst) begin
      // Shadow state follows the block's reset.
      foreach (refcnt[i]) refcnt[i] = '0;
      free_pages = '0;
      lowest = '0;
      limit = 17'd65536;
      errors = 0;
      pending_grants.delete();
    end else begin
      // Register writes.
      if (cfg_we) begin
        if (cfg_index == CFG_LOWEST) lowest = cfg_data;
        else limit = cfg_data;
      end
      // Compare each result transaction with the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        a_page = m_axis_tdata[15:0];
        a_count = m_axis_tdata[32:16];
        a_rel = m_axis_tdata[33];
        a_st = m_axis_tdata[36:34];
        if (pending_grants.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result %h", m_axis_tdata);
        end else begin
          exp_g = pending_grants.pop_front();
          if (a_page !== exp_g.page_out || a_count !== exp_g.count_out ||
              a_rel !== exp_g.page_released || a_st !== exp_g.status ||
              m_axis_tdata[39:37] !== 3'b0) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: expected page %0d count %0d rel %0d st %0d, got %0d %0d %0d %0d",
                       exp_g.page_out, exp_g.count_out, exp_g.page_released, exp_g.status,
                       a_page, a_count, a_rel, a_st);
          end
        end
      end
      // Predict the response of each accepted request.
      if (s_axis_tvalid && s_axis_tready)
        pending_grants.push_back(serve_request(mode_t'(s_axis_tdata[2:0]), s_axis_tdata[18:3]));
    end
  end

endmodule

// ===== verif/refcounted_page_frame_allocator_top_test.sv =====
`timescale 1ns / 100ps

module refcounted_page_frame_allocator_top_test;
  import rpfa_pkg::*;

  localparam int StallLimit = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_LOWEST;
  logic [16:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // mode[2:0], page_number[18:3]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // page_out, count_out, page_released, status
  int          outstanding;
  int          errors;
  int          tx_idle = 32;
  int          rx_idle = 84;
  int          quiet_cycles = 0;

  always #2 clk = ~clk;

  refcounted_page_frame_allocator_top dut (.*);

  refcounted_page_frame_allocator_checker chk (.*);

  // Random backpressure on the result side.
  always @(posedge clk) m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sends one request, with an optional random gap before it.
  task automatic send_req(input mode_t md, input logic [15:0] pg);
    if ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, pg, md};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Waits until the block is idle, then writes both window registers.
  task automatic set_window(input logic [16:0] lo, input logic [16:0] lim);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LOWEST;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_data <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic concentrated on a small set of pages.
  task automatic random_traffic(input int n);
    int r;
    mode_t md;
    logic [15:0] pg;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) md = MODE_ADD;
      else if (r < 35) md = MODE_ALLOC;
      else if (r < 50) md = MODE_FREE;
      else if (r < 65) md = MODE_INC;
      else if (r < 77) md = MODE_DEC;
      else if (r < 88) md = MODE_READ;
      else if (r < 97) md = MODE_TOTAL;
      else md = MODE_NONE;
      if ($urandom_range(0, 99) < 15) pg = 16'($urandom);
      else pg = 16'($urandom_range(0, 40));
      send_req(md, pg);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests with the reset window.
    send_req(MODE_TOTAL, 16'hFFFF);
    send_req(MODE_ALLOC, 16'h0);
    send_req(MODE_READ, 16'h0);
    send_req(MODE_ADD, 16'h0);
    send_req(MODE_ADD, 16'hFFFF);
    send_req(MODE_ADD, 16'd100);
    send_req(MODE_READ, 16'd100);
    send_req(MODE_INC, 16'd100);
    send_req(MODE_DEC, 16'd100);
    send_req(MODE_DEC, 16'd100);
    send_req(MODE_FREE, 16'd100);
    send_req(MODE_ALLOC, 16'h0);
    send_req(MODE_ALLOC, 16'h0);
    send_req(MODE_FREE, 16'd100);
    send_req(MODE_NONE, 16'hFFFF);
    send_req(MODE_TOTAL, 16'h0);
    send_req(MODE_ADD, 16'd7);
    // Raise one count past its maximum.
    repeat (257) send_req(MODE_INC, 16'd7);
    send_req(MODE_READ, 16'd7);
    send_req(MODE_FREE, 16'd7);

    set_window(17'd65536, 17'd65536);
    send_req(MODE_ADD, 16'h0);
    send_req(MODE_READ, 16'hFFFF);
    set_window(17'd3, 17'd30);
    send_req(MODE_INC, 16'd2);
    send_req(MODE_INC, 16'd3);
    send_req(MODE_INC, 16'd29);
    send_req(MODE_FREE, 16'd30);

    // Random phases with changing idling and windows.
    tx_idle = 32;
    rx_idle = 84;
    random_traffic(700);
    set_window(17'd0, 17'd0);
    random_traffic(60);
    set_window(17'd0, 17'd65536);
    tx_idle = 84;
    rx_idle = 32;
    random_traffic(700);
    set_window(17'd5, 17'd25);
    tx_idle = 0;
    rx_idle = 0;
    random_traffic(600);

    // A few closing requests over the whole window.
    set_window(17'd0, 17'd65536);
    send_req(MODE_TOTAL, 16'h0);
    send_req(MODE_ADD, 16'd9);
    send_req(MODE_FREE, 16'd9);
    send_req(MODE_ALLOC, 16'h0);
    send_req(MODE_ALLOC, 16'h0);
    send_req(MODE_TOTAL, 16'h0);
    s_axis_tvalid <= 1'b0;

    // Drain and report.
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
